### rtl/quaternion_vector_alu_macros.svh
// Assertion macros shared by the checker
`ifndef QUATERNION_VECTOR_ALU_MACROS_SVH
`define QUATERNION_VECTOR_ALU_MACROS_SVH
// implication checked on every clock edge outside reset
`define QVA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define QVA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/qva_pkg.sv
// Package with command codes and shared widths for the quaternion/vector ALU
`default_nettype none
package qva_pkg;
  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_QMUL   = 3'd0;
  localparam cmd_t CMD_ROTATE = 3'd1;
  localparam cmd_t CMD_VCROSS = 3'd2;
  localparam cmd_t CMD_VDOT   = 3'd3;
  localparam cmd_t CMD_QDOT   = 3'd4;
  localparam cmd_t CMD_ADD    = 3'd5;
  localparam cmd_t CMD_SUB    = 3'd6;
  localparam cmd_t CMD_SCALE  = 3'd7;
  localparam int IO_WIDTH = 32;
  localparam int PIPE_DEPTH = 6;
endpackage
`default_nettype wire

### rtl/qva_lane.sv
// One multiply lane: four products, shift by the fraction, signed sum of four terms
`default_nettype none
module qva_lane #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [DATA_WIDTH-1:0]  op_a [4],
  input  wire logic signed [DATA_WIDTH-1:0]  op_b [4],
  input  wire logic        [3:0]             neg,
  output logic signed [2*DATA_WIDTH+2:0]     sum_r
);
  localparam int PW = 2*DATA_WIDTH;
  localparam int SW = 2*DATA_WIDTH+3;
  logic signed [PW-1:0] prod_r [4];
  logic        [3:0]    neg_r;
  logic signed [SW-1:0] term [4];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) prod_r[i] <= op_a[i] * op_b[i];
      neg_r <= neg;
    end
  end
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      term[i] = SW'(prod_r[i] >>> FRAC_BITS);
      if (neg_r[i]) term[i] = -term[i];
    end
  end
  always_ff @(posedge clk) begin
    if (en) sum_r <= term[0] + term[1] + term[2] + term[3];
  end
endmodule
`default_nettype wire

### rtl/qva_sat.sv
// Merge stage: clip lane sums to range and collect the clip flag
`default_nettype none
module qva_sat #(
  parameter int DATA_WIDTH = 32,
  parameter int IN_WIDTH   = 67
) (
  input  wire logic signed [IN_WIDTH-1:0]   val,
  output logic signed [DATA_WIDTH-1:0]      res,
  output logic                              clip
);
  localparam logic signed [IN_WIDTH-1:0] HI = (IN_WIDTH'(1) <<< (DATA_WIDTH-1)) - 1;
  localparam logic signed [IN_WIDTH-1:0] LO = -HI - 1;
  always_comb begin
    clip = 1'b1;
    if (val > HI) res = HI[DATA_WIDTH-1:0];
    else if (val < LO) res = LO[DATA_WIDTH-1:0];
    else begin
      res  = val[DATA_WIDTH-1:0];
      clip = 1'b0;
    end
  end
endmodule
`default_nettype wire

### rtl/quaternion_vector_alu.sv
// Top level of the pipelined quaternion / vector ALU
// Every command passes through the same stage registers from input transfer to result.
// Throughput: one item per cycle; the pipe advances whenever the output is not stalled
//   or its output register is empty. Rotate runs its matrix pass and its vector pass in
//   two lane banks in series inside the same six stages.
// Reset: rst_n synchronous, active low, clears all stage valids; payload is not reset.
`default_nettype none
module quaternion_vector_alu #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_command,
  input  wire logic signed [31:0] in_a_w, in_a_x, in_a_y, in_a_z,
  input  wire logic signed [31:0] in_b_w, in_b_x, in_b_y, in_b_z,
  input  wire logic signed [31:0] in_factor,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] out_r_w, out_r_x, out_r_y, out_r_z,
  output logic             out_saturated
);
  localparam int DW = DATA_WIDTH;
  localparam int SW = 2*DW + 3;
  localparam int NS = qva_pkg::PIPE_DEPTH;

  // stage valids, the top bit marks the output register; the whole pipe advances together
  logic [NS:0]   vld_r;
  // simple global enable: move when the last stage is free or being taken
  logic          en;
  assign en       = !vld_r[NS] || !out_stall;
  assign in_stall = !en;
  assign out_valid = vld_r[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[NS-1:0], in_valid};
  end

  // stage 0 capture
  logic signed [DW-1:0] a_r [4], b_r [4];
  logic signed [DW-1:0] f_r;
  qva_pkg::cmd_t        cmd_r [NS];
  always_ff @(posedge clk) begin
    if (en) begin
      if (in_valid) begin
        a_r[0] <= in_a_w[DW-1:0]; a_r[1] <= in_a_x[DW-1:0];
        a_r[2] <= in_a_y[DW-1:0]; a_r[3] <= in_a_z[DW-1:0];
        b_r[0] <= in_b_w[DW-1:0]; b_r[1] <= in_b_x[DW-1:0];
        b_r[2] <= in_b_y[DW-1:0]; b_r[3] <= in_b_z[DW-1:0];
        f_r    <= in_factor[DW-1:0];
      end
      cmd_r[0] <= in_command;
      for (int i = 1; i < NS; i++) cmd_r[i] <= cmd_r[i-1];
    end
  end

  // ---- bank 1: stages 1-2, nine lanes. Lanes 0-3 serve direct commands,
  // lanes 0-8 build rotation coefficients (doubling applied later by a left shift).
  logic signed [DW-1:0] l1a [9][4], l1b [9][4];
  logic [3:0]           l1n [9];
  logic signed [SW-1:0] l1s [9];
  logic signed [DW-1:0] zero;
  assign zero = '0;
  logic signed [DW-1:0] aw, ax, ay, az, bw, bx, by, bz;
  assign {aw, ax, ay, az} = {a_r[0], a_r[1], a_r[2], a_r[3]};
  assign {bw, bx, by, bz} = {b_r[0], b_r[1], b_r[2], b_r[3]};

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      for (int j = 0; j < 4; j++) begin
        l1a[k][j] = zero; l1b[k][j] = zero;
      end
      l1n[k] = 4'b0000;
    end
    case (cmd_r[0])
      qva_pkg::CMD_QMUL: begin
        l1a[0] = '{aw, ax, ay, az}; l1b[0] = '{bw, bx, by, bz}; l1n[0] = 4'b0111;
        l1a[1] = '{aw, ax, ay, az}; l1b[1] = '{bx, bw, bz, by}; l1n[1] = 4'b0001;
        l1a[2] = '{aw, ax, ay, az}; l1b[2] = '{by, bz, bw, bx}; l1n[2] = 4'b0100;
        l1a[3] = '{aw, ax, ay, az}; l1b[3] = '{bz, by, bx, bw}; l1n[3] = 4'b0010;
      end
      qva_pkg::CMD_ROTATE: begin
        // m00 ww+xx-yy-zz, m11 ww-xx+yy-zz, m22 ww-xx-yy+zz
        l1a[0] = '{aw, ax, ay, az}; l1b[0] = '{aw, ax, ay, az}; l1n[0] = 4'b0011;
        l1a[4] = '{aw, ax, ay, az}; l1b[4] = '{aw, ax, ay, az}; l1n[4] = 4'b0101;
        l1a[8] = '{aw, ax, ay, az}; l1b[8] = '{aw, ax, ay, az}; l1n[8] = 4'b0110;
        // off-diagonal halves; doubled after
        l1a[1] = '{ax, aw, zero, zero}; l1b[1] = '{ay, az, zero, zero}; l1n[1] = 4'b0100;
        l1a[2] = '{ax, aw, zero, zero}; l1b[2] = '{az, ay, zero, zero}; l1n[2] = 4'b0000;
        l1a[3] = '{ax, aw, zero, zero}; l1b[3] = '{ay, az, zero, zero}; l1n[3] = 4'b0000;
        l1a[5] = '{ay, aw, zero, zero}; l1b[5] = '{az, ax, zero, zero}; l1n[5] = 4'b0100;
        l1a[6] = '{ax, aw, zero, zero}; l1b[6] = '{az, ay, zero, zero}; l1n[6] = 4'b0100;
        l1a[7] = '{ay, aw, zero, zero}; l1b[7] = '{az, ax, zero, zero}; l1n[7] = 4'b0000;
      end
      qva_pkg::CMD_VCROSS: begin
        l1a[1] = '{ay, az, zero, zero}; l1b[1] = '{bz, by, zero, zero}; l1n[1] = 4'b0100;
        l1a[2] = '{az, ax, zero, zero}; l1b[2] = '{bx, bz, zero, zero}; l1n[2] = 4'b0100;
        l1a[3] = '{ax, ay, zero, zero}; l1b[3] = '{by, bx, zero, zero}; l1n[3] = 4'b0100;
      end
      qva_pkg::CMD_VDOT: begin
        l1a[0] = '{zero, ax, ay, az}; l1b[0] = '{zero, bx, by, bz};
      end
      qva_pkg::CMD_QDOT: begin
        l1a[0] = '{aw, ax, ay, az}; l1b[0] = '{bw, bx, by, bz};
      end
      qva_pkg::CMD_SCALE: begin
        for (int k = 0; k < 4; k++) begin
          l1a[k][0] = a_r[k]; l1b[k][0] = f_r;
        end
      end
      default: ;
    endcase
  end

  // lane numbering bit 3 of neg is term 0: '{t0,t1,t2,t3} and neg[3-i]
  genvar g;
  generate
    for (g = 0; g < 9; g++) begin : g_bank1
      logic [3:0] nrev;
      assign nrev = {l1n[g][0], l1n[g][1], l1n[g][2], l1n[g][3]};
      qva_lane #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_lane (
        .clk(clk), .en(en), .op_a(l1a[g]), .op_b(l1b[g]), .neg(nrev), .sum_r(l1s[g])
      );
    end
  endgenerate

  // add/sub path, aligned with bank 1 (two stages)
  logic signed [SW-1:0] as1_r [4], as2_r [4];
  logic signed [DW-1:0] vb1_r [3], vb2_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        as1_r[k] <= (cmd_r[0] == qva_pkg::CMD_SUB) ? SW'(a_r[k]) - SW'(b_r[k])
                                                   : SW'(a_r[k]) + SW'(b_r[k]);
        as2_r[k] <= as1_r[k];
      end
      for (int k = 0; k < 3; k++) begin
        vb1_r[k] <= b_r[k+1];
        vb2_r[k] <= vb1_r[k];
      end
    end
  end

  // stage 3: coefficient saturation (merge of bank 1), registered
  logic signed [SW-1:0] cf [9];
  logic signed [DW-1:0] m_c [9];
  logic [8:0]           m_clip;
  logic signed [DW-1:0] m_r [9];
  logic                 mflag_r;
  logic signed [SW-1:0] s3_r [4];
  logic signed [DW-1:0] vb3_r [3];
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      if (k == 0 || k == 4 || k == 8) cf[k] = l1s[k];
      else cf[k] = l1s[k] <<< 1;
    end
  end
  generate
    for (g = 0; g < 9; g++) begin : g_msat
      qva_sat #(.DATA_WIDTH(DW), .IN_WIDTH(SW)) u_sat (
        .val(cf[g]), .res(m_c[g]), .clip(m_clip[g])
      );
    end
  endgenerate
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) m_r[k] <= m_c[k];
      mflag_r <= (cmd_r[2] == qva_pkg::CMD_ROTATE) && (|m_clip);
      for (int k = 0; k < 4; k++) begin
        if (cmd_r[2] == qva_pkg::CMD_ADD || cmd_r[2] == qva_pkg::CMD_SUB)
          s3_r[k] <= as2_r[k];
        else s3_r[k] <= l1s[k];
      end
      for (int k = 0; k < 3; k++) vb3_r[k] <= vb2_r[k];
    end
  end

  // bank 2: stages 4-5, three lanes of the rotation matrix times B.xyz
  logic signed [DW-1:0] l2a [3][4], l2b [3][4];
  logic signed [SW-1:0] l2s [3];
  logic signed [SW-1:0] s4_r [4], s5_r [4];
  logic                 f4_r, f5_r;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      l2a[k] = '{m_r[3*k], m_r[3*k+1], m_r[3*k+2], zero};
      l2b[k] = '{vb3_r[0], vb3_r[1], vb3_r[2], zero};
    end
  end
  generate
    for (g = 0; g < 3; g++) begin : g_bank2
      qva_lane #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_lane (
        .clk(clk), .en(en), .op_a(l2a[g]), .op_b(l2b[g]), .neg(4'b0000), .sum_r(l2s[g])
      );
    end
  endgenerate
  always_ff @(posedge clk) begin
    if (en) begin
      s4_r <= s3_r; f4_r <= mflag_r;
      s5_r <= s4_r; f5_r <= f4_r;
    end
  end

  // final merge: pick source, clip, raise flag
  logic signed [SW-1:0] fin [4];
  logic signed [DW-1:0] res [4];
  logic [3:0]           rclip;
  always_comb begin
    fin = s5_r;
    case (cmd_r[NS-1])
      qva_pkg::CMD_ROTATE: begin
        fin[0] = '0; fin[1] = l2s[0]; fin[2] = l2s[1]; fin[3] = l2s[2];
      end
      qva_pkg::CMD_VCROSS: fin[0] = '0;
      qva_pkg::CMD_VDOT, qva_pkg::CMD_QDOT: begin
        fin[1] = '0; fin[2] = '0; fin[3] = '0;
      end
      default: ;
    endcase
  end
  generate
    for (g = 0; g < 4; g++) begin : g_osat
      qva_sat #(.DATA_WIDTH(DW), .IN_WIDTH(SW)) u_sat (
        .val(fin[g]), .res(res[g]), .clip(rclip[g])
      );
    end
  endgenerate
  // hold the output register; load on advance
  logic signed [DW-1:0] o_r [4];
  logic                 osat_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) o_r[k] <= res[k];
      osat_r <= f5_r || (|rclip);
    end
  end
  assign out_r_w = 32'(o_r[0]);
  assign out_r_x = 32'(o_r[1]);
  assign out_r_y = 32'(o_r[2]);
  assign out_r_z = 32'(o_r[3]);
  assign out_saturated = osat_r;
endmodule
`default_nettype wire

### rtl/qva_checker.sv
// Port-level checker for the quaternion/vector ALU, bound to the top level
`default_nettype none
`include "quaternion_vector_alu_macros.svh"
module qva_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic signed [31:0] out_r_w,
  input wire logic out_saturated
);
  // a free output slot never stalls the input
  `QVA_ASSERT_IMP(a_no_stall_free, clk, rst_n, !out_valid, !in_stall)
  // input stall follows only from an output stall
  `QVA_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
  // a stalled result holds its value
  `QVA_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall,
                  out_valid && $stable(out_r_w) && $stable(out_saturated))
  logic unused_iv;
  assign unused_iv = in_valid;
endmodule
bind quaternion_vector_alu qva_checker u_qva_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_r_w(out_r_w),
  .out_saturated(out_saturated)
);
`default_nettype wire

### tb/sv/quaternion_vector_alu_tb.sv
// Self-checking testbench for the quaternion / vector ALU
`default_nettype none
module quaternion_vector_alu_tb;

  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic signed [31:0] MAX_V = 32'sh7fffffff;
  localparam logic signed [31:0] MIN_V = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  typedef struct packed {
    qva_pkg::cmd_t cmd;
    logic signed [31:0] aw, ax, ay, az, bw, bx, by, bz, f;
  } alu_op_t;

  typedef struct packed {
    logic signed [31:0] rw, rx, ry, rz;
    logic sat;
  } alu_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_command = '0;
  logic signed [31:0] in_a_w = '0, in_a_x = '0, in_a_y = '0, in_a_z = '0;
  logic signed [31:0] in_b_w = '0, in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic signed [31:0] in_factor = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_r_w, out_r_x, out_r_y, out_r_z;
  logic out_saturated;

  alu_res_t pending_results[$];
  int mismatch_count = 0;
  int transfer_count = 0;
  int result_count = 0;
  int cycle_count = 0;
  int cmd_hits[8];
  int sat_hits = 0;
  bit stall_enable = 1'b0;

  quaternion_vector_alu dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_a_w(in_a_w), .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_w(in_b_w), .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z),
    .in_factor(in_factor),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_r_w(out_r_w), .out_r_x(out_r_x), .out_r_y(out_r_y), .out_r_z(out_r_z),
    .out_saturated(out_saturated)
  );

  always #5 clk = ~clk;

  // Fixed-point product, arithmetic shift floors toward minus infinity.
  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> FRAC;
  endfunction

  // Clip to 32-bit signed range; raise the clip flag when it bites.
  function automatic longint clip32(longint v, ref bit flag);
    if (v > longint'(MAX_V)) begin
      flag = 1'b1;
      return longint'(MAX_V);
    end
    if (v < longint'(MIN_V)) begin
      flag = 1'b1;
      return longint'(MIN_V);
    end
    return v;
  endfunction

  function automatic alu_res_t alu_predict(alu_op_t op);
    longint aw, ax, ay, az, bw, bx, by, bz, f;
    longint r[4];
    longint ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    bit flag;
    alu_res_t res;
    aw = op.aw; ax = op.ax; ay = op.ay; az = op.az;
    bw = op.bw; bx = op.bx; by = op.by; bz = op.bz; f = op.f;
    r = '{0, 0, 0, 0};
    flag = 1'b0;
    case (op.cmd)
      qva_pkg::CMD_QMUL: begin
        r[0] = fx_mul(aw, bw) - fx_mul(ax, bx) - fx_mul(ay, by) - fx_mul(az, bz);
        r[1] = fx_mul(aw, bx) + fx_mul(ax, bw) + fx_mul(ay, bz) - fx_mul(az, by);
        r[2] = fx_mul(aw, by) - fx_mul(ax, bz) + fx_mul(ay, bw) + fx_mul(az, bx);
        r[3] = fx_mul(aw, bz) + fx_mul(ax, by) - fx_mul(ay, bx) + fx_mul(az, bw);
      end
      qva_pkg::CMD_ROTATE: begin
        ww = fx_mul(aw, aw); xx = fx_mul(ax, ax); yy = fx_mul(ay, ay); zz = fx_mul(az, az);
        xy = fx_mul(ax, ay); xz = fx_mul(ax, az); yz = fx_mul(ay, az);
        wx = fx_mul(aw, ax); wy = fx_mul(aw, ay); wz = fx_mul(aw, az);
        // matrix coefficients clip before the vector pass
        m00 = clip32(ww + xx - yy - zz, flag);
        m01 = clip32(2 * (xy - wz), flag);
        m02 = clip32(2 * (xz + wy), flag);
        m10 = clip32(2 * (xy + wz), flag);
        m11 = clip32(ww - xx + yy - zz, flag);
        m12 = clip32(2 * (yz - wx), flag);
        m20 = clip32(2 * (xz - wy), flag);
        m21 = clip32(2 * (yz + wx), flag);
        m22 = clip32(ww - xx - yy + zz, flag);
        r[1] = fx_mul(m00, bx) + fx_mul(m01, by) + fx_mul(m02, bz);
        r[2] = fx_mul(m10, bx) + fx_mul(m11, by) + fx_mul(m12, bz);
        r[3] = fx_mul(m20, bx) + fx_mul(m21, by) + fx_mul(m22, bz);
      end
      qva_pkg::CMD_VCROSS: begin
        r[1] = fx_mul(ay, bz) - fx_mul(az, by);
        r[2] = fx_mul(az, bx) - fx_mul(ax, bz);
        r[3] = fx_mul(ax, by) - fx_mul(ay, bx);
      end
      qva_pkg::CMD_VDOT: r[0] = fx_mul(ax, bx) + fx_mul(ay, by) + fx_mul(az, bz);
      qva_pkg::CMD_QDOT:
        r[0] = fx_mul(aw, bw) + fx_mul(ax, bx) + fx_mul(ay, by) + fx_mul(az, bz);
      qva_pkg::CMD_ADD: begin
        r[0] = aw + bw; r[1] = ax + bx; r[2] = ay + by; r[3] = az + bz;
      end
      qva_pkg::CMD_SUB: begin
        r[0] = aw - bw; r[1] = ax - bx; r[2] = ay - by; r[3] = az - bz;
      end
      default: begin
        r[0] = fx_mul(aw, f); r[1] = fx_mul(ax, f);
        r[2] = fx_mul(ay, f); r[3] = fx_mul(az, f);
      end
    endcase
    res.rw = 32'(clip32(r[0], flag));
    res.rx = 32'(clip32(r[1], flag));
    res.ry = 32'(clip32(r[2], flag));
    res.rz = 32'(clip32(r[3], flag));
    res.sat = flag;
    return res;
  endfunction

  // Drive one operation at the falling edge and hold it until the transfer.
  task automatic send_op(alu_op_t op);
    @(negedge clk);
    in_valid <= 1'b1;
    in_command <= op.cmd;
    in_a_w <= op.aw; in_a_x <= op.ax; in_a_y <= op.ay; in_a_z <= op.az;
    in_b_w <= op.bw; in_b_x <= op.bx; in_b_y <= op.by; in_b_z <= op.bz;
    in_factor <= op.f;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(alu_predict(op));
    cmd_hits[op.cmd]++;
    transfer_count++;
  endtask

  // Drop valid for a random gap, then advance.
  task automatic idle_gap(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 7))
      0: return MAX_V;
      1: return MIN_V;
      2: return 32'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536);
      3: return 32'($signed($urandom_range(0, 2048)) - 1024);
      4: return ($urandom_range(0, 1)) ? ONE : -ONE;
      default: return $urandom;
    endcase
  endfunction

  function automatic alu_op_t rand_op();
    alu_op_t op;
    op.cmd = qva_pkg::cmd_t'($urandom_range(0, 7));
    op.aw = rand_val(); op.ax = rand_val(); op.ay = rand_val(); op.az = rand_val();
    op.bw = rand_val(); op.bx = rand_val(); op.by = rand_val(); op.bz = rand_val();
    op.f = rand_val();
    return op;
  endfunction

  // Every command at the edges of the range plus the unit cases.
  task automatic test_directed();
    alu_op_t op;
    for (int c = 0; c < 8; c++) begin
      op = '{qva_pkg::cmd_t'(c), MAX_V, MIN_V, MAX_V, MIN_V, MIN_V, MAX_V, MIN_V, MAX_V,
             MAX_V};
      send_op(op);
      op = '{qva_pkg::cmd_t'(c), ONE, 32'sh8000, -ONE, 32'sh18000, -ONE, ONE, 32'sh20000,
             -32'sh8000, -32'sh8000};
      send_op(op);
    end
    // identity rotation, and a 90 degree rotation about z
    send_op('{qva_pkg::CMD_ROTATE, ONE, 0, 0, 0, MIN_V, ONE, -ONE, MAX_V, 0});
    send_op('{qva_pkg::CMD_ROTATE, 32'sh0000b505, 0, 0, 32'sh0000b505, 0, ONE, 2 * ONE,
              0, 0});
    send_op('{qva_pkg::CMD_SUB, MIN_V, MAX_V, 0, -1, 1, -1, 0, MIN_V, 0});
    send_op('{qva_pkg::CMD_SCALE, -1, 1, MIN_V, MAX_V, 0, 0, 0, 0, -1});
    send_op('{qva_pkg::CMD_QMUL, -1, -1, -1, -1, 1, 1, 1, 1, 0});
    send_op('{qva_pkg::CMD_VDOT, MIN_V, 0, 0, 0, MAX_V, 0, 0, 0, 0});
  endtask

  // Random operations in bursts with random gaps.
  task automatic test_random(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && n > 0; i++) begin
        send_op(rand_op());
        n--;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(0, 6));
    end
  endtask

  // Back-to-back operations with no gaps on the sender side.
  task automatic test_full_rate(int n);
    for (int i = 0; i < n; i++) send_op(rand_op());
  endtask

  // Receiver stall pattern: long open stretches mixed with random and bursty stall.
  always @(negedge clk) begin
    if (!stall_enable) begin
      out_stall <= 1'b0;
    end else begin
      case ((cycle_count / 64) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 2) == 0);
        2: out_stall <= ((cycle_count % 8) < 5);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    alu_res_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result transfer at cycle %0d", cycle_count);
      end else begin
        want = pending_results.pop_front();
        if (want.sat) sat_hits++;
        if (want.rw !== out_r_w || want.rx !== out_r_x || want.ry !== out_r_y ||
            want.rz !== out_r_z || want.sat !== out_saturated) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch #%0d: want w=%h x=%h y=%h z=%h s=%b got w=%h x=%h y=%h z=%h s=%b",
                     result_count, want.rw, want.rx, want.ry, want.rz, want.sat,
                     out_r_w, out_r_x, out_r_y, out_r_z, out_saturated);
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[quaternion_vector_alu] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    stall_enable = 1'b1;
    test_random(300);
    test_full_rate(100);
    test_random(125);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d transfers, %0d saturating; per command: %0d %0d %0d %0d %0d %0d %0d %0d",
             transfer_count, sat_hits, cmd_hits[0], cmd_hits[1], cmd_hits[2], cmd_hits[3],
             cmd_hits[4], cmd_hits[5], cmd_hits[6], cmd_hits[7]);
    $display("%0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("[quaternion_vector_alu] OK");
    end else begin
      $display("[quaternion_vector_alu] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
